### design/flash_command_interface_top_macros.svh
// assertion macros shared by the flash command interface rtl
`ifndef FLASH_COMMAND_INTERFACE_TOP_MACROS_SVH
`define FLASH_COMMAND_INTERFACE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define FCI_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fci assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define FCI_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fci assertion failed");
`else
`define FCI_ASSERT_IMP(name, ante, cons)
`define FCI_ASSERT_NEXT(name, ante, cons)
`endif
`endif

### design/fci_pkg.sv
// shared types and constants of the flash command interface
package fci_pkg;

    localparam int ADDR_W          = 20;
    localparam int DATA_W          = 8;
    localparam int MODE_W          = 4;
    localparam int ADDR_BITS_DEF   = 20;
    localparam int BLOCK_BITS_DEF  = 16;

    // chip modes
    localparam logic [MODE_W-1:0] M_ARRAY       = 4'd0;
    localparam logic [MODE_W-1:0] M_ID          = 4'd1;
    localparam logic [MODE_W-1:0] M_STATUS      = 4'd2;
    localparam logic [MODE_W-1:0] M_ERASE_SETUP = 4'd3;
    localparam logic [MODE_W-1:0] M_ERASING     = 4'd4;
    localparam logic [MODE_W-1:0] M_SUSPENDED   = 4'd5;
    localparam logic [MODE_W-1:0] M_SUSP_STATUS = 4'd6;
    localparam logic [MODE_W-1:0] M_PROG_SETUP  = 4'd7;
    localparam logic [MODE_W-1:0] M_PROG_DONE   = 4'd8;

    // bus commands
    localparam logic [DATA_W-1:0] CMD_READ_ARRAY   = 8'hFF;
    localparam logic [DATA_W-1:0] CMD_READ_ID      = 8'h90;
    localparam logic [DATA_W-1:0] CMD_READ_STATUS  = 8'h70;
    localparam logic [DATA_W-1:0] CMD_CLEAR_STATUS = 8'h50;
    localparam logic [DATA_W-1:0] CMD_ERASE_SETUP  = 8'h20;
    localparam logic [DATA_W-1:0] CMD_PROGRAM      = 8'h40;
    localparam logic [DATA_W-1:0] CMD_PROGRAM_ALT  = 8'h10;
    localparam logic [DATA_W-1:0] CMD_CONFIRM      = 8'hD0;
    localparam logic [DATA_W-1:0] CMD_SUSPEND      = 8'hB0;

    // read values
    localparam logic [DATA_W-1:0] ID_MFR       = 8'h89;
    localparam logic [DATA_W-1:0] ID_DEV       = 8'hA2;
    localparam logic [DATA_W-1:0] ERASED_BYTE  = 8'hFF;
    localparam logic [DATA_W-1:0] STS_READY    = 8'h80;
    localparam logic [DATA_W-1:0] STS_SUSP_CLR = 8'hBF;

    // decoded effect of one transaction
    typedef struct packed {
        logic [MODE_W-1:0] mode_next;
        logic [DATA_W-1:0] status_next;
        logic              load_erase_addr;
        logic              load_prog_addr;
        logic              prog_write;
        logic              start_erase;
        logic              array_read;
        logic [DATA_W-1:0] rd_value;
    } cmd_t;

endpackage

### design/fci_req_if.sv
// request channel: bus read or write toward the flash
interface fci_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [fci_pkg::ADDR_W-1:0]  address;
    logic [fci_pkg::DATA_W-1:0]  write_data;

    modport source (output valid, output action, output address, output write_data,
                    input ready);
    modport sink   (input valid, input action, input address, input write_data,
                    output ready);
endinterface

### design/fci_rsp_if.sv
// response channel: byte returned for each bus transaction
interface fci_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [fci_pkg::DATA_W-1:0]  read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

### design/fci_array.sv
// flash array storage: one write port, one registered read port
module fci_array #(
    parameter int ADDR_BITS = fci_pkg::ADDR_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_BITS-1:0]       wr_addr,
    input  logic [fci_pkg::DATA_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_BITS-1:0]       rd_addr,
    output logic [fci_pkg::DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [fci_pkg::DATA_W-1:0] mem [DEPTH];
    logic [fci_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/fci_cmd.sv
// command mode decoder: next mode, status and array actions per transaction
module fci_cmd #(
    parameter int ADDR_BITS = fci_pkg::ADDR_BITS_DEF
) (
    input  logic [fci_pkg::MODE_W-1:0] mode,
    input  logic [fci_pkg::DATA_W-1:0] status,
    input  logic [ADDR_BITS-1:0]       erase_addr,
    input  logic [ADDR_BITS-1:0]       prog_addr,
    input  logic                       is_write,
    input  logic [ADDR_BITS-1:0]       addr,
    input  logic [fci_pkg::DATA_W-1:0] data,
    output fci_pkg::cmd_t              ctl
);

    logic is_program;

    assign is_program = (data == fci_pkg::CMD_PROGRAM) || (data == fci_pkg::CMD_PROGRAM_ALT);

    always_comb
    begin
        ctl             = '0;
        ctl.mode_next   = mode;
        ctl.status_next = status;
        ctl.rd_value    = fci_pkg::ERASED_BYTE;
        if (is_write)
        begin
            unique case (mode) inside
                fci_pkg::M_ARRAY:
                begin
                    if (data == fci_pkg::CMD_READ_ARRAY)
                    begin
                        ctl.status_next = '0;
                    end
                    else if (data == fci_pkg::CMD_READ_ID)
                    begin
                        ctl.mode_next = fci_pkg::M_ID;
                    end
                    else if (data == fci_pkg::CMD_READ_STATUS)
                    begin
                        ctl.mode_next = fci_pkg::M_STATUS;
                    end
                    else if (data == fci_pkg::CMD_CLEAR_STATUS)
                    begin
                        ctl.status_next = '0;
                    end
                    else if (data == fci_pkg::CMD_ERASE_SETUP)
                    begin
                        ctl.load_erase_addr = 1'b1;
                        ctl.mode_next       = fci_pkg::M_ERASE_SETUP;
                    end
                    else if (is_program)
                    begin
                        ctl.load_prog_addr = 1'b1;
                        ctl.mode_next      = fci_pkg::M_PROG_SETUP;
                    end
                end
                fci_pkg::M_PROG_DONE:
                begin
                    if (is_program)
                    begin
                        ctl.load_prog_addr = 1'b1;
                        ctl.mode_next      = fci_pkg::M_PROG_SETUP;
                    end
                    else if (data == fci_pkg::CMD_READ_ARRAY)
                    begin
                        ctl.mode_next = fci_pkg::M_ARRAY;
                    end
                end
                fci_pkg::M_ID, fci_pkg::M_STATUS, fci_pkg::M_SUSP_STATUS:
                begin
                    if (data == fci_pkg::CMD_READ_ARRAY)
                    begin
                        ctl.mode_next = fci_pkg::M_ARRAY;
                    end
                end
                fci_pkg::M_ERASE_SETUP:
                begin
                    // confirm only at the setup address, else abort
                    if ((addr == erase_addr) && (data == fci_pkg::CMD_CONFIRM))
                    begin
                        ctl.mode_next   = fci_pkg::M_ERASING;
                        ctl.start_erase = 1'b1;
                        ctl.status_next = status | fci_pkg::STS_READY;
                    end
                    else
                    begin
                        ctl.mode_next = fci_pkg::M_ARRAY;
                    end
                end
                fci_pkg::M_ERASING:
                begin
                    if (data == fci_pkg::CMD_SUSPEND)
                    begin
                        ctl.mode_next = fci_pkg::M_SUSPENDED;
                    end
                    else if (data == fci_pkg::CMD_READ_ARRAY)
                    begin
                        ctl.mode_next = fci_pkg::M_ARRAY;
                    end
                end
                fci_pkg::M_SUSPENDED:
                begin
                    if (data == fci_pkg::CMD_CONFIRM)
                    begin
                        ctl.mode_next = fci_pkg::M_ERASING;
                    end
                    else if (data == fci_pkg::CMD_READ_ARRAY)
                    begin
                        ctl.mode_next = fci_pkg::M_ARRAY;
                    end
                    else if (data == fci_pkg::CMD_READ_STATUS)
                    begin
                        ctl.mode_next   = fci_pkg::M_SUSP_STATUS;
                        ctl.status_next = (status | fci_pkg::STS_READY) & fci_pkg::STS_SUSP_CLR;
                    end
                end
                fci_pkg::M_PROG_SETUP:
                begin
                    // data lands only at the setup address
                    ctl.prog_write  = (addr == prog_addr);
                    ctl.status_next = status | fci_pkg::STS_READY;
                    ctl.mode_next   = fci_pkg::M_PROG_DONE;
                end
                default:
                begin
                    ctl.mode_next   = fci_pkg::M_ARRAY;
                    ctl.status_next = '0;
                end
            endcase
        end
        else
        begin
            unique case (mode) inside
                fci_pkg::M_ARRAY, fci_pkg::M_ERASE_SETUP:
                begin
                    ctl.array_read = 1'b1;
                end
                fci_pkg::M_PROG_DONE, fci_pkg::M_STATUS, fci_pkg::M_ERASING,
                fci_pkg::M_SUSPENDED, fci_pkg::M_SUSP_STATUS:
                begin
                    ctl.rd_value = status;
                end
                fci_pkg::M_ID:
                begin
                    ctl.rd_value = addr[0] ? fci_pkg::ID_DEV : fci_pkg::ID_MFR;
                end
                default:
                begin
                    ctl.rd_value = fci_pkg::ERASED_BYTE;
                end
            endcase
        end
    end

endmodule

### design/flash_command_interface_top.sv
// top level of the flash command interface: sequencer, output register, array
//
//  channel  modport  direction  payload
//  req      sink     in         action, address, write_data
//  rsp      source   out        read_data
//
//  array reads pass the synchronous read port and the read state, others answer directly,
//  then its response sits in the output register until rsp.ready
//  after reset the array is swept to 0xFF, all 2**ADDR_BITS bytes (1048576 by default)
//  an erase confirm answers at once, then sweeps its block of 2**BLOCK_BITS bytes
//  (65536 at the default); req.ready is low during either sweep
//  req.ready also stays low while a response waits and rsp.ready is low
`include "flash_command_interface_top_macros.svh"

module flash_command_interface_top #(
    parameter int ADDR_BITS  = fci_pkg::ADDR_BITS_DEF,
    parameter int BLOCK_BITS = fci_pkg::BLOCK_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fci_req_if.sink   req,
    fci_rsp_if.source rsp
);

    // sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_ERASE = 2'd3;

    // low bits that select a byte inside one erase block
    localparam logic [ADDR_BITS-1:0] BLK_MASK =
        ADDR_BITS'((64'd1 << BLOCK_BITS) - 64'd1);

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [fci_pkg::MODE_W-1:0] mode_reg;
    logic [fci_pkg::DATA_W-1:0] status_reg;
    logic [ADDR_BITS-1:0]       erase_addr_reg;
    logic [ADDR_BITS-1:0]       prog_addr_reg;
    logic [ADDR_BITS-1:0]       sweep_cnt_reg;
    logic                       rsp_valid_reg;
    logic [fci_pkg::DATA_W-1:0] rsp_data_reg;

    logic                       accept;
    logic [ADDR_BITS-1:0]       addr_int;
    logic                       sweep_last;
    fci_pkg::cmd_t              ctl;

    logic                       wr_en;
    logic [ADDR_BITS-1:0]       wr_addr;
    logic [fci_pkg::DATA_W-1:0] wr_data;
    logic                       rd_en;
    logic [fci_pkg::DATA_W-1:0] mem_rd_data;

    // address bits above ADDR_BITS are ignored, missing ones read as zero
    assign addr_int  = ADDR_BITS'(req.address);

    // one transaction at a time; the output slot must be free or emptying
    assign req.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    fci_cmd #(
        .ADDR_BITS (ADDR_BITS)
    ) u_cmd (
        .mode       (mode_reg),
        .status     (status_reg),
        .erase_addr (erase_addr_reg),
        .prog_addr  (prog_addr_reg),
        .is_write   (req.action),
        .addr       (addr_int),
        .data       (req.write_data),
        .ctl        (ctl)
    );

    // array reads go through the memory read register and then the output register
    assign rd_en = accept && !req.action && ctl.array_read;

    // clearing pass ends at the top address, an erase at the block end
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            sweep_last = (sweep_cnt_reg == '1);
        end
        else
        begin
            sweep_last = ((sweep_cnt_reg & BLK_MASK) == BLK_MASK);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_CLEAR, ST_ERASE:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (rd_en)
                begin
                    state_next = ST_READ;
                end
                else if (accept && ctl.start_erase)
                begin
                    state_next = ST_ERASE;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // write port: sweep writes 0xff, otherwise program data
    always_comb
    begin
        if ((state_reg == ST_CLEAR) || (state_reg == ST_ERASE))
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_cnt_reg;
            wr_data = fci_pkg::ERASED_BYTE;
        end
        else
        begin
            wr_en   = accept && ctl.prog_write;
            wr_addr = addr_int;
            wr_data = req.write_data;
        end
    end

    fci_array #(
        .ADDR_BITS (ADDR_BITS)
    ) u_array (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_int),
        .rd_data (mem_rd_data)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            mode_reg      <= fci_pkg::M_ARRAY;
            status_reg    <= '0;
            sweep_cnt_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                mode_reg   <= ctl.mode_next;
                status_reg <= ctl.status_next;
            end
            // sweep counter: run during a pass, start an erase at its block base
            if ((state_reg == ST_CLEAR) || (state_reg == ST_ERASE))
            begin
                sweep_cnt_reg <= sweep_cnt_reg + ADDR_BITS'(1);
            end
            else if (accept && ctl.start_erase)
            begin
                sweep_cnt_reg <= addr_int & ~BLK_MASK;
            end
            // output slot
            if (accept && !rd_en)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (state_reg == ST_READ)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept && ctl.load_erase_addr)
        begin
            erase_addr_reg <= addr_int;
        end
        if (accept && ctl.load_prog_addr)
        begin
            prog_addr_reg <= addr_int;
        end
        if (accept && !rd_en)
        begin
            // writes answer with zero
            rsp_data_reg <= req.action ? '0 : ctl.rd_value;
        end
        else if (state_reg == ST_READ)
        begin
            rsp_data_reg <= mem_rd_data;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rsp_data_reg;

    // an array read parks the sequencer with the output slot empty
    `FCI_ASSERT_NEXT(a_read_waits, rd_en, (state_reg == ST_READ) && !rsp_valid_reg)
    // nothing new is taken while array data is on its way
    `FCI_ASSERT_IMP(a_read_blocks, state_reg == ST_READ, !rsp_valid_reg && !req.ready)
    // an erase confirm starts its sweep at the block base
    `FCI_ASSERT_NEXT(a_erase_base, accept && ctl.start_erase,
                     (state_reg == ST_ERASE) && ((sweep_cnt_reg & BLK_MASK) == '0))
    // a program write leaves the chip done with ready status
    `FCI_ASSERT_NEXT(a_prog_done, wr_en && (state_reg == ST_IDLE),
                     status_reg[7] && (mode_reg == fci_pkg::M_PROG_DONE))

endmodule
